// ===== hdl/mh2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mh2_pkg;

  localparam logic [31:0] MIX_M      = 32'h5bd1e995;
  localparam int unsigned MIX_R      = 24;
  localparam int unsigned FIN_A      = 13;
  localparam int unsigned FIN_B      = 15;
  localparam logic [31:0] SEED_RESET = 32'd97;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_PART,
    KIND_FULL
  } kind_e;

  // one classified word; data is the mixed k for a full word, masked bytes otherwise
  typedef struct packed {
    kind_e       kind;
    logic [31:0] data;
    logic        first;
    logic        last;
    logic [15:0] len;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ===== hdl/murmur2_key_hash.sv =====
// Channel   Direction  Handshake              Payload
// word in   input      in_valid_i/in_stall_o  word_data, valid_bytes, key_start, key_end, key_length
// hash out  output     out_valid_o/out_stall_i hash_out
// seed cfg  input      cfg_valid_i/cfg_ready_o cfg_data_i (hash_seed)
//
// One word per cycle sustained while out_stall_i is low; the running-hash multiply and XOR in
// the back part sets that rate. A taken word is registered in the front stage, then queued;
// a key's last word sets the finish flag, and the hash is then registered in the output stage.
// Reset clears all valid flags, the running hash to 0 and the seed to 97.
// A two-entry queue between the word mixer and the hash loop absorbs output stalls.
`timescale 1ns / 1ps
`default_nettype none
module murmur2_key_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] word_data_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        key_start_i,
  input  wire logic        key_end_i,
  input  wire logic [15:0] key_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_out_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  logic                 q_push;
  logic                 q_pop;
  mh2_pkg::item_t       q_in;
  mh2_pkg::item_t       q_out;
  mh2_pkg::queue_stat_t q_stat;
  logic [31:0]          seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mh2_pkg::SEED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_data_i;
    end
  end

  mh2_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_data_i   (word_data_i),
    .valid_bytes_i (valid_bytes_i),
    .key_start_i   (key_start_i),
    .key_end_i     (key_end_i),
    .key_length_i  (key_length_i),
    .push_o        (q_push),
    .item_o        (q_in),
    .stat_i        (q_stat)
  );

  mh2_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  mh2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .item_i      (q_out),
    .stat_i      (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_out_o  (hash_out_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_stat.empty))
    else $error("queue pop while empty");

  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("queue lost an entry without a pop");
`endif

endmodule
`default_nettype wire

// ===== hdl/mh2_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mh2_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [31:0]          word_data_i,
  input  wire logic [2:0]           valid_bytes_i,
  input  wire logic                 key_start_i,
  input  wire logic                 key_end_i,
  input  wire logic [15:0]          key_length_i,
  output logic                      push_o,
  output mh2_pkg::item_t            item_o,
  input  wire mh2_pkg::queue_stat_t stat_i
);

  logic                s1_valid_q, s1_valid_d;
  logic [31:0]         prod_q, prod_d;
  logic [31:0]         part_q, part_d;
  mh2_pkg::kind_e      kind_q, kind_d;
  logic                first_q, last_q;
  logic [15:0]         len_q;
  logic                load;
  logic [31:0]         k_mix;

  assign push_o     = s1_valid_q && !stat_i.full;
  assign in_stall_o = s1_valid_q && !push_o;
  assign load       = in_valid_i && !in_stall_o;

  // classify by byte count and mask off bytes past the count
  always_comb begin
    prod_d = word_data_i * mh2_pkg::MIX_M;
    case (valid_bytes_i)
      3'd0: begin
        kind_d = mh2_pkg::KIND_EMPTY;
        part_d = '0;
      end
      3'd1: begin
        kind_d = mh2_pkg::KIND_PART;
        part_d = {24'd0, word_data_i[7:0]};
      end
      3'd2: begin
        kind_d = mh2_pkg::KIND_PART;
        part_d = {16'd0, word_data_i[15:0]};
      end
      3'd3: begin
        kind_d = mh2_pkg::KIND_PART;
        part_d = {8'd0, word_data_i[23:0]};
      end
      default: begin
        kind_d = mh2_pkg::KIND_FULL;
        part_d = word_data_i;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q  <= prod_d;
      part_q  <= part_d;
      kind_q  <= kind_d;
      first_q <= key_start_i;
      last_q  <= key_end_i;
      len_q   <= key_length_i;
    end
  end

  // finish the word mix on the way into the queue
  assign k_mix = (prod_q ^ (prod_q >> mh2_pkg::MIX_R)) * mh2_pkg::MIX_M;

  always_comb begin
    item_o.kind  = kind_q;
    item_o.data  = (kind_q == mh2_pkg::KIND_FULL) ? k_mix : part_q;
    item_o.first = first_q;
    item_o.last  = last_q;
    item_o.len   = len_q;
  end

endmodule
`default_nettype wire

// ===== hdl/mh2_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mh2_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire mh2_pkg::item_t       item_i,
  input  wire logic                 pop_i,
  output mh2_pkg::item_t            item_o,
  output mh2_pkg::queue_stat_t      stat_o
);

  mh2_pkg::item_t                   mem_q [mh2_pkg::QDEPTH];
  logic [mh2_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mh2_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mh2_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == mh2_pkg::QCNT_W'(mh2_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mh2_pkg::QPTR_W'(mh2_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mh2_pkg::QPTR_W'(mh2_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mh2_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mh2_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [31:0]          seed_i,
  input  wire mh2_pkg::item_t       item_i,
  input  wire mh2_pkg::queue_stat_t stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [31:0]               hash_out_o
);

  logic [31:0] hash_q, hash_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q;
  logic        fin_move;
  logic [31:0] base;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic [31:0] fin_x;

  assign fin_move = fin_q && (!out_valid_q || !out_stall_i);
  assign pop_o    = !stat_i.empty && (!fin_q || fin_move);

  // running hash update: the only feedback loop, one multiply per word
  always_comb begin
    base   = item_i.first ? (seed_i ^ {16'd0, item_i.len}) : hash_q;
    mul_in = (item_i.kind == mh2_pkg::KIND_FULL) ? base : (base ^ item_i.data);
    prod   = mul_in * mh2_pkg::MIX_M;
    case (item_i.kind)
      mh2_pkg::KIND_FULL: hash_d = prod ^ item_i.data;
      mh2_pkg::KIND_PART: hash_d = prod;
      default:            hash_d = base;
    endcase
  end

  always_comb begin
    fin_d = fin_q;
    if (pop_o) begin
      fin_d = item_i.last;
    end else if (fin_move) begin
      fin_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fin_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hash_q <= hash_d;
      end
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // closing mix, first half; the running hash still holds the finished key here
  assign fin_x = hash_q ^ (hash_q >> mh2_pkg::FIN_A);

  always_ff @(posedge clk_i) begin
    if (fin_move) begin
      out_q <= fin_x * mh2_pkg::MIX_M;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_out_o  = out_q ^ (out_q >> mh2_pkg::FIN_B);

endmodule
`default_nettype wire
